// ----- design/cau_pkg.sv -----
// Shared definitions for the complex arithmetic unit.
// Operation codes, status codes and the control bundle that moves along the pipeline.
// No dependencies.
`timescale 1ns / 1ps

package cau_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int OP_W           = 4;
    localparam int STAT_W         = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_RECIP = 4'd4,
        OP_MOD   = 4'd5,
        OP_CONJ  = 4'd6,
        OP_NEG   = 4'd7,
        OP_EQ    = 4'd8
    } op_t;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DIV0 = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SAT  = 2'd2;

    // Per-item control that travels beside the data words.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            divzero;
        logic            eq;
        logic            neg_re;
        logic            neg_im;
        logic            ovf_re;
        logic            ovf_im;
    } ctl_t;

endpackage

// ----- design/cau_front.sv -----
// Front end of the complex arithmetic unit: products, sums, operand selection
// and divider setup over three register stages. Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_front #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
    localparam int W   = DATA_WIDTH,
    localparam int PW  = 2 * DATA_WIDTH + 1,
    localparam int NW  = 2 * DATA_WIDTH + 2 * FRAC_BITS,
    localparam int CW  = 3 * DATA_WIDTH + 2 * FRAC_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [cau_pkg::OP_W-1:0]       in_op,
    input  logic signed [W-1:0]            in_ar,
    input  logic signed [W-1:0]            in_ai,
    input  logic signed [W-1:0]            in_br,
    input  logic signed [W-1:0]            in_bi,
    output logic                           out_valid,
    output cau_pkg::ctl_t                  out_ctl,
    output logic signed [PW-1:0]           out_pre_re,
    output logic signed [PW-1:0]           out_pre_im,
    output logic [CW-1:0]                  out_rem_re,
    output logic [CW-1:0]                  out_rem_im,
    output logic [2*W-1:0]                 out_den,
    output logic [2*W-1:0]                 out_sqx
);

    // Stage 1: operands and the eight partial products.
    logic                     v1_reg;
    logic [cau_pkg::OP_W-1:0] op1_reg;
    logic signed [W-1:0]      ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic signed [2*W-1:0]    arbr_reg, aibi_reg, arbi_reg, aibr_reg;
    logic signed [2*W-1:0]    arar_reg, aiai_reg, brbr_reg, bibi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg  <= in_op;
            ar1_reg  <= in_ar;
            ai1_reg  <= in_ai;
            br1_reg  <= in_br;
            bi1_reg  <= in_bi;
            arbr_reg <= in_ar * in_br;
            aibi_reg <= in_ai * in_bi;
            arbi_reg <= in_ar * in_bi;
            aibr_reg <= in_ai * in_br;
            arar_reg <= in_ar * in_ar;
            aiai_reg <= in_ai * in_ai;
            brbr_reg <= in_br * in_br;
            bibi_reg <= in_bi * in_bi;
        end
    end

    // Stage 2: sums of products and per-operation selection.
    logic signed [PW-1:0]  mre, mim, dre, dim;
    logic [2*W-1:0]        maga, magb;
    logic signed [PW-1:0]  pre_re_next, pre_im_next;
    logic signed [NW:0]    num_re_next, num_im_next;
    logic [2*W-1:0]        den_next;
    cau_pkg::ctl_t         ctl2_next;

    always_comb begin
        mre  = PW'(arbr_reg) - PW'(aibi_reg);
        mim  = PW'(arbi_reg) + PW'(aibr_reg);
        dre  = PW'(arbr_reg) + PW'(aibi_reg);
        dim  = PW'(aibr_reg) - PW'(arbi_reg);
        maga = $unsigned(arar_reg) + $unsigned(aiai_reg);
        magb = $unsigned(brbr_reg) + $unsigned(bibi_reg);

        pre_re_next = '0;
        pre_im_next = '0;
        num_re_next = '0;
        num_im_next = '0;
        den_next    = magb;
        ctl2_next   = '0;
        ctl2_next.op = op1_reg;

        case (op1_reg)
            cau_pkg::OP_ADD: begin
                pre_re_next = PW'(ar1_reg) + PW'(br1_reg);
                pre_im_next = PW'(ai1_reg) + PW'(bi1_reg);
            end
            cau_pkg::OP_SUB: begin
                pre_re_next = PW'(ar1_reg) - PW'(br1_reg);
                pre_im_next = PW'(ai1_reg) - PW'(bi1_reg);
            end
            cau_pkg::OP_MUL: begin
                pre_re_next = mre >>> FRAC_BITS;
                pre_im_next = mim >>> FRAC_BITS;
            end
            cau_pkg::OP_DIV: begin
                num_re_next       = (NW+1)'(dre) <<< FRAC_BITS;
                num_im_next       = (NW+1)'(dim) <<< FRAC_BITS;
                den_next          = magb;
                ctl2_next.divzero = (magb == '0);
            end
            cau_pkg::OP_RECIP: begin
                num_re_next       = (NW+1)'(ar1_reg) <<< (2 * FRAC_BITS);
                num_im_next       = -((NW+1)'(ai1_reg) <<< (2 * FRAC_BITS));
                den_next          = maga;
                ctl2_next.divzero = (maga == '0);
            end
            cau_pkg::OP_CONJ: begin
                pre_re_next = PW'(ar1_reg);
                pre_im_next = -PW'(ai1_reg);
            end
            cau_pkg::OP_NEG: begin
                pre_re_next = -PW'(ar1_reg);
                pre_im_next = -PW'(ai1_reg);
            end
            cau_pkg::OP_EQ: begin
                ctl2_next.eq = (ar1_reg == br1_reg) && (ai1_reg == bi1_reg);
            end
            default: begin
            end
        endcase
    end

    logic                  v2_reg;
    cau_pkg::ctl_t         ctl2_reg;
    logic signed [PW-1:0]  pre2_re_reg, pre2_im_reg;
    logic signed [NW:0]    num2_re_reg, num2_im_reg;
    logic [2*W-1:0]        den2_reg, sqx2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl2_reg    <= ctl2_next;
            pre2_re_reg <= pre_re_next;
            pre2_im_reg <= pre_im_next;
            num2_re_reg <= num_re_next;
            num2_im_reg <= num_im_next;
            den2_reg    <= den_next;
            sqx2_reg    <= maga;
        end
    end

    // Stage 3: magnitudes of the numerators and the quotient range check.
    logic [NW-1:0]  mag_re, mag_im;
    logic [CW-1:0]  den_top;
    cau_pkg::ctl_t  ctl3_next;

    always_comb begin
        mag_re  = num2_re_reg[NW] ? NW'(-num2_re_reg) : NW'(num2_re_reg);
        mag_im  = num2_im_reg[NW] ? NW'(-num2_im_reg) : NW'(num2_im_reg);
        den_top = CW'(den2_reg) << W;
        ctl3_next        = ctl2_reg;
        ctl3_next.neg_re = num2_re_reg[NW];
        ctl3_next.neg_im = num2_im_reg[NW];
        ctl3_next.ovf_re = (CW'(mag_re) >= den_top);
        ctl3_next.ovf_im = (CW'(mag_im) >= den_top);
    end

    logic v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_ctl    <= ctl3_next;
            out_pre_re <= pre2_re_reg;
            out_pre_im <= pre2_im_reg;
            out_rem_re <= CW'(mag_re);
            out_rem_im <= CW'(mag_im);
            out_den    <= den2_reg;
            out_sqx    <= sqx2_reg;
        end
    end

    assign out_valid = v3_reg;

endmodule

// ----- design/cau_divsqrt.sv -----
// Pipelined restoring divider (two lanes) and digit-by-digit square root.
// One quotient bit and one root bit per register stage. Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_divsqrt #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
    localparam int W   = DATA_WIDTH,
    localparam int PW  = 2 * DATA_WIDTH + 1,
    localparam int CW  = 3 * DATA_WIDTH + 2 * FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  cau_pkg::ctl_t         in_ctl,
    input  logic signed [PW-1:0]  in_pre_re,
    input  logic signed [PW-1:0]  in_pre_im,
    input  logic [CW-1:0]         in_rem_re,
    input  logic [CW-1:0]         in_rem_im,
    input  logic [2*W-1:0]        in_den,
    input  logic [2*W-1:0]        in_sqx,
    output logic                  out_valid,
    output cau_pkg::ctl_t         out_ctl,
    output logic signed [PW-1:0]  out_pre_re,
    output logic signed [PW-1:0]  out_pre_im,
    output logic [W-1:0]          out_q_re,
    output logic [W-1:0]          out_q_im,
    output logic                  out_rnz_re,
    output logic                  out_rnz_im,
    output logic [W-1:0]          out_root
);

    logic                  v_s    [0:W];
    cau_pkg::ctl_t         ctl_s  [0:W];
    logic signed [PW-1:0]  pre_re_s [0:W];
    logic signed [PW-1:0]  pre_im_s [0:W];
    logic [CW-1:0]         rre_s  [0:W];
    logic [CW-1:0]         rim_s  [0:W];
    logic [W-1:0]          qre_s  [0:W];
    logic [W-1:0]          qim_s  [0:W];
    logic [2*W-1:0]        den_s  [0:W];
    logic [2*W-1:0]        sx_s   [0:W];
    logic [2*W-1:0]        sr_s   [0:W];

    assign v_s[0]      = in_valid;
    assign ctl_s[0]    = in_ctl;
    assign pre_re_s[0] = in_pre_re;
    assign pre_im_s[0] = in_pre_im;
    assign rre_s[0]    = in_rem_re;
    assign rim_s[0]    = in_rem_im;
    assign qre_s[0]    = '0;
    assign qim_s[0]    = '0;
    assign den_s[0]    = in_den;
    assign sx_s[0]     = in_sqx;
    assign sr_s[0]     = '0;

    for (genvar k = 0; k < W; k++) begin : g_stage
        localparam int SH = W - 1 - k;

        logic [CW-1:0]  dsub;
        logic           ge_re, ge_im;
        logic [2*W:0]   sbit, trial;
        logic           take;

        always_comb begin
            dsub  = CW'(den_s[k]) << SH;
            ge_re = (rre_s[k] >= dsub);
            ge_im = (rim_s[k] >= dsub);
            // Root step: the trial value is the partial root plus the current bit pair.
            sbit  = (2*W+1)'(1) << (2 * SH);
            trial = (2*W+1)'(sr_s[k]) + sbit;
            take  = ((2*W+1)'(sx_s[k]) >= trial);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_s[k+1] <= 1'b0;
            end else if (en) begin
                v_s[k+1] <= v_s[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ctl_s[k+1]    <= ctl_s[k];
                pre_re_s[k+1] <= pre_re_s[k];
                pre_im_s[k+1] <= pre_im_s[k];
                den_s[k+1]    <= den_s[k];
                rre_s[k+1]    <= ge_re ? rre_s[k] - dsub : rre_s[k];
                rim_s[k+1]    <= ge_im ? rim_s[k] - dsub : rim_s[k];
                qre_s[k+1]    <= qre_s[k] | (W'(ge_re) << SH);
                qim_s[k+1]    <= qim_s[k] | (W'(ge_im) << SH);
                if (take) begin
                    sx_s[k+1] <= sx_s[k] - trial[2*W-1:0];
                    sr_s[k+1] <= (sr_s[k] >> 1) + sbit[2*W-1:0];
                end else begin
                    sx_s[k+1] <= sx_s[k];
                    sr_s[k+1] <= sr_s[k] >> 1;
                end
            end
        end
    end

    assign out_valid  = v_s[W];
    assign out_ctl    = ctl_s[W];
    assign out_pre_re = pre_re_s[W];
    assign out_pre_im = pre_im_s[W];
    assign out_q_re   = qre_s[W];
    assign out_q_im   = qim_s[W];
    assign out_rnz_re = (rre_s[W] != '0);
    assign out_rnz_im = (rim_s[W] != '0);
    assign out_root   = sr_s[W][W-1:0];

endmodule

// ----- design/cau_back.sv -----
// Result stage: floor correction of quotients, result selection, saturation
// and status, into the output register. Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_back #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    localparam int W  = DATA_WIDTH,
    localparam int PW = 2 * DATA_WIDTH + 1,
    localparam int XW = 2 * DATA_WIDTH + 2
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  cau_pkg::ctl_t               in_ctl,
    input  logic signed [PW-1:0]        in_pre_re,
    input  logic signed [PW-1:0]        in_pre_im,
    input  logic [W-1:0]                in_q_re,
    input  logic [W-1:0]                in_q_im,
    input  logic                        in_rnz_re,
    input  logic                        in_rnz_im,
    input  logic [W-1:0]                in_root,
    output logic                        out_valid,
    output logic [W-1:0]                out_res_real,
    output logic [W-1:0]                out_res_imag,
    output logic                        out_equal_flag,
    output logic [cau_pkg::STAT_W-1:0]  out_status
);

    localparam logic signed [XW-1:0] DMAX = (XW'(1) <<< (W - 1)) - XW'(1);
    localparam logic signed [XW-1:0] DMIN = -DMAX - XW'(1);

    function automatic logic signed [XW-1:0] quot(input logic [W-1:0] q, input logic rnz,
                                                  input logic neg, input logic ovf);
        logic signed [XW-1:0] qs;
        qs = signed'(XW'(q));
        if (ovf) begin
            quot = neg ? DMIN - XW'(1) : DMAX + XW'(1);
        end else if (neg) begin
            // Floor of a negative quotient rounds the magnitude up.
            quot = -(qs + signed'(XW'(rnz)));
        end else begin
            quot = qs;
        end
    endfunction

    logic signed [XW-1:0]         vre, vim, cre, cim;
    logic                         compute, over;
    logic [cau_pkg::STAT_W-1:0]   status_next;

    always_comb begin
        vre     = '0;
        vim     = '0;
        compute = 1'b1;
        case (in_ctl.op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL,
            cau_pkg::OP_CONJ, cau_pkg::OP_NEG: begin
                vre = XW'(in_pre_re);
                vim = XW'(in_pre_im);
            end
            cau_pkg::OP_DIV, cau_pkg::OP_RECIP: begin
                compute = !in_ctl.divzero;
                vre = quot(in_q_re, in_rnz_re, in_ctl.neg_re, in_ctl.ovf_re);
                vim = quot(in_q_im, in_rnz_im, in_ctl.neg_im, in_ctl.ovf_im);
            end
            cau_pkg::OP_MOD: begin
                vre = signed'(XW'(in_root));
            end
            default: begin
                compute = 1'b0;
            end
        endcase

        cre  = (vre > DMAX) ? DMAX : ((vre < DMIN) ? DMIN : vre);
        cim  = (vim > DMAX) ? DMAX : ((vim < DMIN) ? DMIN : vim);
        over = compute && ((vre > DMAX) || (vre < DMIN) || (vim > DMAX) || (vim < DMIN));
        if (!compute) begin
            cre = '0;
            cim = '0;
        end

        if (in_ctl.divzero) begin
            status_next = cau_pkg::STAT_DIV0;
        end else if (over) begin
            status_next = cau_pkg::STAT_SAT;
        end else begin
            status_next = cau_pkg::STAT_OK;
        end
    end

    logic out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_res_real   <= cre[W-1:0];
            out_res_imag   <= cim[W-1:0];
            out_equal_flag <= in_ctl.eq;
            out_status     <= status_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- design/complex_arithmetic_unit_core.sv -----
// Complex arithmetic unit, top level: stream ports and pipeline assembly.
// Uses cau_pkg, cau_front, cau_divsqrt and cau_back.
//
// Usage: each input item carries an operation code and two complex operands
// in signed fixed point (DATA_WIDTH bits, FRAC_BITS fraction bits). The unit
// returns one result item per input item, in order: real and imaginary part,
// an equality flag and a status code (ok, divide by zero, saturated).
// From acceptance to m_tvalid an item passes three front stages for products,
// sums and divider setup, one stage per quotient and root bit, and the output
// register.
// Throughput is one item per cycle while m_tready is high; the divider and
// square root are unrolled into one bit per stage.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps

module complex_arithmetic_unit_core #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
    localparam int S_W = ((cau_pkg::OP_W + 4 * DATA_WIDTH + 7) / 8) * 8,
    localparam int M_W = ((2 * DATA_WIDTH + 1 + cau_pkg::STAT_W + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    // operation, a_real, a_imag, b_real, b_imag (lowest bits first)
    input  logic [S_W-1:0] s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    // res_real, res_imag, equal_flag, status (lowest bits first)
    output logic [M_W-1:0] m_tdata
);

    localparam int W   = DATA_WIDTH;
    localparam int PW  = 2 * DATA_WIDTH + 1;
    localparam int CW  = 3 * DATA_WIDTH + 2 * FRAC_BITS;
    localparam int OW  = cau_pkg::OP_W;
    localparam int MPAD = M_W - (2 * W + 1 + cau_pkg::STAT_W);

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic                 f_valid;
    cau_pkg::ctl_t        f_ctl;
    logic signed [PW-1:0] f_pre_re, f_pre_im;
    logic [CW-1:0]        f_rem_re, f_rem_im;
    logic [2*W-1:0]       f_den, f_sqx;

    cau_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_op     (s_tdata[OW-1:0]),
        .in_ar     (s_tdata[OW +: W]),
        .in_ai     (s_tdata[OW + W +: W]),
        .in_br     (s_tdata[OW + 2 * W +: W]),
        .in_bi     (s_tdata[OW + 3 * W +: W]),
        .out_valid (f_valid),
        .out_ctl   (f_ctl),
        .out_pre_re(f_pre_re),
        .out_pre_im(f_pre_im),
        .out_rem_re(f_rem_re),
        .out_rem_im(f_rem_im),
        .out_den   (f_den),
        .out_sqx   (f_sqx)
    );

    logic                 d_valid;
    cau_pkg::ctl_t        d_ctl;
    logic signed [PW-1:0] d_pre_re, d_pre_im;
    logic [W-1:0]         d_q_re, d_q_im, d_root;
    logic                 d_rnz_re, d_rnz_im;

    cau_divsqrt #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_divsqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_ctl    (f_ctl),
        .in_pre_re (f_pre_re),
        .in_pre_im (f_pre_im),
        .in_rem_re (f_rem_re),
        .in_rem_im (f_rem_im),
        .in_den    (f_den),
        .in_sqx    (f_sqx),
        .out_valid (d_valid),
        .out_ctl   (d_ctl),
        .out_pre_re(d_pre_re),
        .out_pre_im(d_pre_im),
        .out_q_re  (d_q_re),
        .out_q_im  (d_q_im),
        .out_rnz_re(d_rnz_re),
        .out_rnz_im(d_rnz_im),
        .out_root  (d_root)
    );

    logic [W-1:0]                res_real, res_imag;
    logic                        equal_flag;
    logic [cau_pkg::STAT_W-1:0]  status;

    cau_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (d_valid),
        .in_ctl        (d_ctl),
        .in_pre_re     (d_pre_re),
        .in_pre_im     (d_pre_im),
        .in_q_re       (d_q_re),
        .in_q_im       (d_q_im),
        .in_rnz_re     (d_rnz_re),
        .in_rnz_im     (d_rnz_im),
        .in_root       (d_root),
        .out_valid     (m_tvalid),
        .out_res_real  (res_real),
        .out_res_imag  (res_imag),
        .out_equal_flag(equal_flag),
        .out_status    (status)
    );

    assign m_tdata = {{MPAD{1'b0}}, status, equal_flag, res_imag, res_real};

endmodule
